// ----- rtl/core/shl_pkg.sv -----
`default_nettype none

package shl_pkg;

  localparam int TCNT_W  = 7;
  localparam int BCNT_W  = 9;
  localparam int MAX_RES = 6;
  localparam int RCNT_W  = 3;

  localparam logic [TCNT_W-1:0] MAX_TOKENS  = 7'd64;
  localparam logic [BCNT_W-1:0] TOKEN_BYTES = 9'd256;

  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_BAR   = 8'h7c;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_GT    = 8'h3e;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_LT    = 8'h3c;
  localparam logic [7:0] CH_DOL   = 8'h24;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [2:0] EV_SEP  = 3'd0;
  localparam logic [2:0] EV_RED  = 3'd1;
  localparam logic [2:0] EV_VAR  = 3'd2;
  localparam logic [2:0] EV_CMD  = 3'd3;
  localparam logic [2:0] EV_BYTE = 3'd4;
  localparam logic [2:0] EV_EOL  = 3'd5;

  localparam logic [2:0] SEP_BG   = 3'd0;
  localparam logic [2:0] SEP_AND  = 3'd1;
  localparam logic [2:0] SEP_PIPE = 3'd2;
  localparam logic [2:0] SEP_OR   = 3'd3;
  localparam logic [2:0] SEP_SEMI = 3'd4;

  localparam logic [1:0] TGT_OUT  = 2'd0;
  localparam logic [1:0] TGT_BOTH = 2'd1;
  localparam logic [1:0] TGT_ERR  = 2'd2;
  localparam logic [1:0] TGT_IN   = 2'd3;

  typedef enum logic [2:0] {
    M_NONE, M_AMP, M_BAR, M_GT, M_GTGT, M_TWO, M_TWOGT, M_SKIP
  } lex_mode_t;

  typedef enum logic [2:0] {
    T_NONE, T_SEP, T_RED, T_VAR, T_CMD
  } tok_type_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_line;
  } in_word_t;

  typedef struct packed {
    logic [2:0]        event_res;
    logic [TCNT_W-1:0] token_number;
    logic [2:0]        separator;
    logic [1:0]        redirect_target;
    logic              append_mode;
    logic [7:0]        byte_value;
    logic              overflow;
    logic              last_result;
  } out_word_t;

  typedef struct packed {
    lex_mode_t         mode;
    tok_type_t         ctype;
    logic              prev_space;
    logic [TCNT_W-1:0] tcount;
    logic [BCNT_W-1:0] bcount;
    logic [1:0]        ptgt;
    logic              papp;
  } lex_state_t;

  typedef struct packed {
    logic [RCNT_W-1:0]          cnt;
    out_word_t [MAX_RES-1:0]    w;
  } res_list_t;

  localparam lex_state_t LEX_RESET = '{
    mode: M_NONE, ctype: T_NONE, prev_space: 1'b1,
    tcount: '0, bcount: '0, ptgt: TGT_OUT, papp: 1'b0
  };

endpackage

`default_nettype wire

// ----- rtl/core/shl_step.sv -----
`default_nettype none

module shl_step
  import shl_pkg::*;
(
  input  lex_state_t st,
  input  in_word_t   in_word,
  output lex_state_t st_nxt,
  output res_list_t  res
);

  typedef struct packed {
    lex_state_t s;
    res_list_t  l;
  } ctx_t;

  localparam logic [RCNT_W-1:0] RES_LIMIT = RCNT_W'(MAX_RES);

  function automatic out_word_t mk(logic [2:0] ev, logic [TCNT_W-1:0] tn,
                                   logic [2:0] sep, logic [1:0] tgt,
                                   logic app, logic [7:0] b, logic ovf);
    out_word_t w;
    w.event_res       = ev;
    w.token_number    = tn;
    w.separator       = sep;
    w.redirect_target = tgt;
    w.append_mode     = app;
    w.byte_value      = b;
    w.overflow        = ovf;
    w.last_result     = 1'b0;
    return w;
  endfunction

  function automatic res_list_t push(res_list_t l, out_word_t w);
    res_list_t r;
    r = l;
    if (l.cnt < RES_LIMIT) begin
      r.w[l.cnt] = w;
      r.cnt      = l.cnt + 1'b1;
    end
    return r;
  endfunction

  function automatic ctx_t open_tok(ctx_t x, tok_type_t t, output logic ovf);
    ctx_t y;
    y = x;
    y.s.ctype = t;
    if (x.s.tcount < MAX_TOKENS) begin
      y.s.tcount = x.s.tcount + 1'b1;
      y.s.bcount = '0;
      ovf        = 1'b0;
    end else begin
      y.s.bcount = TOKEN_BYTES;
      ovf        = 1'b1;
    end
    return y;
  endfunction

  function automatic ctx_t add_byte(ctx_t x, logic [7:0] c);
    ctx_t y;
    logic o;
    y = x;
    o = 1'b1;
    if (x.s.bcount < TOKEN_BYTES) begin
      y.s.bcount = x.s.bcount + 1'b1;
      o          = 1'b0;
    end
    y.l = push(y.l, mk(EV_BYTE, y.s.tcount, SEP_BG, TGT_OUT, 1'b0, c, o));
    return y;
  endfunction

  function automatic ctx_t emit_sep(ctx_t x, logic [2:0] sep);
    ctx_t y;
    logic o;
    y = open_tok(x, T_SEP, o);
    y.l = push(y.l, mk(EV_SEP, y.s.tcount, sep, TGT_OUT, 1'b0, 8'h00, o));
    return y;
  endfunction

  function automatic ctx_t emit_red(ctx_t x, logic [1:0] tgt, logic app);
    ctx_t y;
    logic o;
    y = open_tok(x, T_RED, o);
    y.l = push(y.l, mk(EV_RED, y.s.tcount, SEP_BG, tgt, app, 8'h00, o));
    y.s.mode = M_SKIP;
    y.s.ptgt = TGT_OUT;
    y.s.papp = 1'b0;
    return y;
  endfunction

  function automatic ctx_t cmd_start(ctx_t x);
    ctx_t y;
    logic o;
    y = open_tok(x, T_CMD, o);
    y.l = push(y.l, mk(EV_CMD, y.s.tcount, SEP_BG, TGT_OUT, 1'b0, 8'h00, o));
    return y;
  endfunction

  function automatic ctx_t text(ctx_t x, logic [7:0] c);
    ctx_t y;
    y = x;
    if (x.s.ctype == T_CMD) begin
      y = add_byte(y, c);
    end else if (x.s.ctype == T_RED || x.s.ctype == T_VAR) begin
      if (c == CH_SPACE) y = cmd_start(y);
      y = add_byte(y, c);
    end else begin
      y = cmd_start(y);
      y = add_byte(y, c);
    end
    return y;
  endfunction

  function automatic ctx_t plain(ctx_t x, logic [7:0] c);
    ctx_t y;
    logic o;
    y = x;
    o = 1'b0;
    unique case (c)
      CH_AMP:  y.s.mode = M_AMP;
      CH_BAR:  y.s.mode = M_BAR;
      CH_SEMI: y = emit_sep(y, SEP_SEMI);
      CH_GT: begin
        y.s.mode = M_GT;
        y.s.ptgt = TGT_OUT;
        y.s.papp = 1'b0;
      end
      CH_LT:   y = emit_red(y, TGT_IN, 1'b0);
      CH_DOL: begin
        y = open_tok(y, T_VAR, o);
        y.l = push(y.l, mk(EV_VAR, y.s.tcount, SEP_BG, TGT_OUT, 1'b0, 8'h00, o));
      end
      CH_TWO: begin
        if (x.s.prev_space) y.s.mode = M_TWO;
        else y = text(y, c);
      end
      default: y = text(y, c);
    endcase
    return y;
  endfunction

  function automatic ctx_t feed(ctx_t x, logic [7:0] c);
    ctx_t y;
    logic done;
    y = x;
    done = 1'b0;
    unique case (x.s.mode)
      M_AMP: begin
        y.s.mode = M_NONE;
        if (c == CH_AMP) begin
          y = emit_sep(y, SEP_AND);
          done = 1'b1;
        end else begin
          y = emit_sep(y, SEP_BG);
        end
      end
      M_BAR: begin
        y.s.mode = M_NONE;
        if (c == CH_BAR) begin
          y = emit_sep(y, SEP_OR);
          done = 1'b1;
        end else begin
          y = emit_sep(y, SEP_PIPE);
        end
      end
      M_GT: begin
        if (c == CH_GT) begin
          y.s.mode = M_GTGT;
          y.s.papp = 1'b1;
          done = 1'b1;
        end else if (c == CH_AMP) begin
          y = emit_red(y, TGT_BOTH, 1'b0);
          done = 1'b1;
        end else begin
          y = emit_red(y, TGT_OUT, 1'b0);
        end
      end
      M_GTGT: begin
        if (c == CH_AMP) begin
          y = emit_red(y, TGT_BOTH, 1'b1);
          done = 1'b1;
        end else begin
          y = emit_red(y, TGT_OUT, 1'b1);
        end
      end
      M_TWO: begin
        if (c == CH_GT) begin
          y.s.mode = M_TWOGT;
          y.s.ptgt = TGT_ERR;
          y.s.papp = 1'b0;
          done = 1'b1;
        end else begin
          y.s.mode = M_NONE;
          y = text(y, CH_TWO);
        end
      end
      M_TWOGT: begin
        if (c == CH_GT) begin
          y = emit_red(y, TGT_ERR, 1'b1);
          done = 1'b1;
        end else begin
          y = emit_red(y, TGT_ERR, 1'b0);
        end
      end
      M_NONE, M_SKIP: ;
    endcase
    if (!done) begin
      if (y.s.mode == M_SKIP && c == CH_SPACE) begin
        done = 1'b1;
      end else begin
        if (y.s.mode == M_SKIP) y.s.mode = M_NONE;
        y = plain(y, c);
      end
    end
    return y;
  endfunction

  function automatic ctx_t flush(ctx_t x);
    ctx_t y;
    y = x;
    unique case (x.s.mode)
      M_AMP:                 y = emit_sep(y, SEP_BG);
      M_BAR:                 y = emit_sep(y, SEP_PIPE);
      M_GT, M_GTGT, M_TWOGT: y = emit_red(y, x.s.ptgt, x.s.papp);
      M_TWO:                 y = text(y, CH_TWO);
      M_NONE, M_SKIP: ;
    endcase
    y.l = push(y.l, mk(EV_EOL, y.s.tcount, SEP_BG, TGT_OUT, 1'b0, 8'h00, 1'b0));
    return y;
  endfunction

  ctx_t cx;

  always_comb begin
    cx.s = st;
    cx.l = '0;
    cx = feed(cx, in_word.char_code);
    cx.s.prev_space = (in_word.char_code == CH_SPACE);
    if (in_word.end_of_line) begin
      cx = flush(cx);
      cx.s = LEX_RESET;
    end
    if (cx.l.cnt != '0) cx.l.w[cx.l.cnt - 1'b1].last_result = 1'b1;
    st_nxt = cx.s;
    res    = cx.l;
  end

endmodule

`default_nettype wire

// ----- rtl/core/shl_drain.sv -----
`default_nettype none

module shl_drain
  import shl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load_valid,
  output logic      load_ready,
  input  res_list_t load_list,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  out_word_t [MAX_RES-1:0] bank_r;
  logic [RCNT_W-1:0]       cnt_r, cnt_nxt;
  logic [RCNT_W-1:0]       idx_r, idx_nxt;
  logic                    last_take;

  assign out_valid  = idx_r < cnt_r;
  assign out_data   = bank_r[idx_r];
  assign last_take  = out_valid && out_ready && (idx_r == cnt_r - 1'b1);
  assign load_ready = !out_valid || last_take;

  always_comb begin
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    if (load_valid && load_ready) begin
      cnt_nxt = load_list.cnt;
      idx_nxt = '0;
    end else if (out_valid && out_ready) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && load_ready) bank_r <= load_list.w;
  end

endmodule

`default_nettype wire

// ----- rtl/core/shell_command_lexer.sv -----
`default_nettype none

// Channel  Ports                          Word
// input    in_valid / in_ready / in_data    in_word_t: one byte, end-of-line flag
// result   out_valid / out_ready / out_data out_word_t: one token event
//
// One result word leaves per cycle while out_ready is high. The result bank
// takes the next input word once it is empty or as its last result is taken,
// so plain text bytes flow at one word per cycle. Results come from the input
// register, then the result bank. The bank drain sets the throughput.
// rst_n clears the lexer state and empties the input register and bank.
// in_ready is high while the input register is empty or can load the bank.
module shell_command_lexer
  import shl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  in_word_t   in_r;
  logic       in_full_r, in_full_nxt;
  lex_state_t state_r, state_nxt;
  res_list_t  step_res;
  logic       bank_ready;
  logic       advance;

  assign advance  = in_full_r && bank_ready;
  assign in_ready = !in_full_r || advance;

  shl_step u_step (
    .st      (state_r),
    .in_word (in_r),
    .st_nxt  (state_nxt),
    .res     (step_res)
  );

  shl_drain u_drain (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (in_full_r),
    .load_ready (bank_ready),
    .load_list  (step_res),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  always_comb begin
    in_full_nxt = in_full_r;
    if (in_valid && in_ready) in_full_nxt = 1'b1;
    else if (advance) in_full_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r <= 1'b0;
      state_r   <= LEX_RESET;
    end else begin
      in_full_r <= in_full_nxt;
      if (advance) state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_r <= in_data;
  end

endmodule

`default_nettype wire
